/* hw/rtl/pdc_pkg.sv */
`default_nettype none

package pdc_pkg;

  localparam int DATA_W  = 32;
  localparam int DRIVE_W = 12;
  localparam int SUM_W   = 48;
  localparam int ACC_W   = 64;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DRIVE_MAX     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_MIN     = 3'd4;
  localparam logic [IDX_W-1:0] REG_BASE_VALUE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAPTURE_BASE  = 3'd6;

  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic [DATA_W-1:0]  RST_PROP_GAIN     = 32'd19660800;
  localparam logic [DATA_W-1:0]  RST_INTEGRAL_GAIN = 32'd26214;
  localparam logic [DATA_W-1:0]  RST_DERIV_GAIN    = 32'd8192000;
  localparam logic [DRIVE_W-1:0] RST_DRIVE_MAX     = 12'd2000;
  localparam logic [DRIVE_W-1:0] RST_DRIVE_MIN     = 12'd1000;
  localparam logic [DRIVE_W-1:0] RST_BASE_VALUE    = 12'd1500;

  // multiplier steps: the product issued at step k is absorbed at step k+1
  localparam int MCNT_W = 3;
  localparam logic [MCNT_W-1:0] MSTEP_P    = 3'd0;
  localparam logic [MCNT_W-1:0] MSTEP_ILO  = 3'd1;
  localparam logic [MCNT_W-1:0] MSTEP_IHI  = 3'd2;
  localparam logic [MCNT_W-1:0] MSTEP_D    = 3'd3;
  localparam logic [MCNT_W-1:0] MSTEP_DONE = 3'd4;

  // radix-4 divider: two quotient bits per cycle over a 64-bit dividend
  localparam int DCNT_W = 5;
  localparam logic [DCNT_W-1:0] DIV_LAST = 5'd31;

  localparam int ACNT_W = 2;
  localparam logic [ACNT_W-1:0] ASTEP_P = 2'd0;
  localparam logic [ACNT_W-1:0] ASTEP_I = 2'd1;
  localparam logic [ACNT_W-1:0] ASTEP_D = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_TERM,
    ST_ACC,
    ST_FIN,
    ST_RESTART
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/pid_drive_with_integral_clamp.sv */
// Update beat: load, multiply, divide (skipped when time_step is zero), term, accumulate,
// then the result is registered once the output is free; a new beat is taken back in IDLE.
// The update rate is set by the radix-4 divider behind one shared 32x32 multiplier.
// Restart beat: the result is registered in ST_RESTART once the output is free, then IDLE.
// Reset (rst, synchronous): registers to their reset values, sums cleared,
// last drive and base 1500, no result pending.
`default_nettype none

module pid_drive_with_integral_clamp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic signed [pdc_pkg::DATA_W-1:0] error,
  input  logic [pdc_pkg::DATA_W-1:0]       time_step,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pdc_pkg::DRIVE_W-1:0]      drive_value,
  output logic                             drive_clamped,
  output logic                             integral_clamped,
  output logic                             step_zero,
  input  logic                             cfg_we,
  input  logic [pdc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pdc_pkg::DATA_W-1:0]       cfg_data
);

  localparam int DW   = pdc_pkg::DATA_W;
  localparam int RW   = pdc_pkg::DRIVE_W;
  localparam int SW   = pdc_pkg::SUM_W;
  localparam int AW   = pdc_pkg::ACC_W;
  localparam int PI_W = SW + DW;
  localparam int IC_W = FRAC_BITS + 14;
  localparam int IS_W = FRAC_BITS + 15;

  localparam logic [IC_W-1:0] I_CAP = {1'b1, {(IC_W-1){1'b0}}};
  localparam logic [AW-1:0]   D_CAP = {2'b01, {(AW-2){1'b0}}};
  localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

  pdc_pkg::state_t state, state_next;

  logic [pdc_pkg::MCNT_W-1:0] mcnt;
  logic [pdc_pkg::DCNT_W-1:0] dcnt;
  logic [pdc_pkg::ACNT_W-1:0] acnt;

  logic [DW-1:0] prop_gain, integral_gain, deriv_gain;
  logic [RW-1:0] drive_max, drive_min, base_value;
  logic          capture_base;

  logic signed [SW-1:0] error_sum;
  logic signed [DW-1:0] last_error;
  logic [RW-1:0]        last_drive, offset_level;

  logic signed [DW-1:0] err_q;
  logic [DW-1:0]        dt_q;
  logic                 s_p, s_i, s_d;
  logic [DW-1:0]        mag_p, mag_d;
  logic [SW-1:0]        mag_i;
  logic [AW-1:0]        mul_q, prod_p, div_n;
  logic [PI_W-1:0]      prod_i;
  logic [DW-1:0]        rem;
  logic signed [AW-1:0] term_p, term_i, term_d, acc;
  logic                 iclamp_q;

  logic in_take, out_free, out_load;

  // ---- operand magnitudes
  logic [DW-1:0]        err_u, ep_mag;
  logic signed [SW:0]   ai;
  logic [SW:0]          ai_neg;
  logic [SW-1:0]        ai_mag;
  logic signed [DW:0]   ad;
  logic [DW:0]          ad_neg;
  logic [DW-1:0]        ad_mag;

  always_comb begin
    err_u  = err_q;
    ep_mag = err_q[DW-1] ? (32'd0 - err_u) : err_u;
    ai     = (SW+1)'(err_q) + (SW+1)'(error_sum);
    ai_neg = (SW+1)'(0) - ai;
    ai_mag = ai[SW] ? ai_neg[SW-1:0] : ai[SW-1:0];
    ad     = (DW+1)'(err_q) - (DW+1)'(last_error);
    ad_neg = (DW+1)'(0) - ad;
    ad_mag = ad[DW] ? ad_neg[DW-1:0] : ad[DW-1:0];
  end

  // ---- shared multiplier
  logic [DW-1:0] mul_a, mul_b;
  logic [AW-1:0] mul_prod;

  always_comb begin
    case (mcnt)
      pdc_pkg::MSTEP_P: begin
        mul_a = mag_p;
        mul_b = prop_gain;
      end
      pdc_pkg::MSTEP_ILO: begin
        mul_a = mag_i[DW-1:0];
        mul_b = integral_gain;
      end
      pdc_pkg::MSTEP_IHI: begin
        mul_a = DW'(mag_i[SW-1:DW]);
        mul_b = integral_gain;
      end
      default: begin
        mul_a = mag_d;
        mul_b = deriv_gain;
      end
    endcase
    mul_prod = AW'(mul_a) * AW'(mul_b);
  end

  // ---- divider step, two bits
  logic [DW:0] r1, r2;
  logic [DW:0] r1s, r2s;
  logic        ge1, ge2;

  always_comb begin
    r1  = {rem, div_n[AW-1]};
    ge1 = r1 >= {1'b0, dt_q};
    r1s = ge1 ? (r1 - {1'b0, dt_q}) : r1;
    r2  = {r1s[DW-1:0], div_n[AW-2]};
    ge2 = r2 >= {1'b0, dt_q};
    r2s = ge2 ? (r2 - {1'b0, dt_q}) : r2;
  end

  // ---- term formation and integral limit
  logic [AW-1:0]          pmag, dmag;
  logic [PI_W-1:0]        imag;
  logic [IC_W-1:0]        icap;
  logic signed [IS_W-1:0] i_s, lim, i_fin;
  logic signed [RW:0]     span;
  logic                   iclamp;
  logic signed [AW-1:0]   p_val, d_val;

  always_comb begin
    pmag  = prod_p >> FRAC_BITS;
    p_val = s_p ? (AW'(0) - pmag) : pmag;
    imag  = prod_i >> FRAC_BITS;
    icap  = (|(imag >> (FRAC_BITS + 13))) ? I_CAP : imag[IC_W-1:0];
    i_s   = s_i ? (IS_W'(0) - {1'b0, icap}) : {1'b0, icap};
    span  = (RW+1)'(drive_max) - (RW+1)'(drive_min);
    lim   = IS_W'(span) <<< FRAC_BITS;
    if (i_s >= lim) begin
      i_fin  = lim;
      iclamp = 1'b1;
    end else if (i_s <= -lim) begin
      i_fin  = -lim;
      iclamp = 1'b1;
    end else begin
      i_fin  = i_s;
      iclamp = 1'b0;
    end
    if (dt_q == '0) begin
      dmag = '0;
    end else begin
      dmag = (|div_n[AW-1:AW-2]) ? D_CAP : div_n;
    end
    d_val = s_d ? (AW'(0) - dmag) : dmag;
  end

  // ---- shared accumulator
  logic signed [AW-1:0] addend;

  always_comb begin
    case (acnt)
      pdc_pkg::ASTEP_P: addend = term_p;
      pdc_pkg::ASTEP_I: addend = term_i;
      default:          addend = term_d;
    endcase
  end

  // ---- truncate to integer, bound the drive and saturate the error sum
  logic [AW-1:0]        vmag, tmag;
  logic signed [AW-1:0] t, dmax_s, dmin_s;
  logic [RW-1:0]        t_drive;
  logic                 dclamp;
  logic signed [SW:0]   es_sum;
  logic signed [SW-1:0] es_next;

  always_comb begin
    vmag   = acc[AW-1] ? (AW'(0) - acc) : acc;
    tmag   = vmag >> FRAC_BITS;
    t      = acc[AW-1] ? (AW'(0) - tmag) : tmag;
    dmax_s = AW'(drive_max);
    dmin_s = AW'(drive_min);
    if (t >= dmax_s) begin
      t_drive = drive_max;
      dclamp  = 1'b1;
    end else if (t <= dmin_s) begin
      t_drive = drive_min;
      dclamp  = 1'b1;
    end else begin
      t_drive = t[RW-1:0];
      dclamp  = 1'b0;
    end
    es_sum = (SW+1)'(error_sum) + (SW+1)'(err_q);
    if (es_sum[SW] != es_sum[SW-1]) begin
      es_next = es_sum[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      es_next = es_sum[SW-1:0];
    end
  end

  // ---- sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_free   = !out_valid || out_ready;
    out_load   = 1'b0;
    case (state)
      pdc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (kind == pdc_pkg::KIND_RESTART) ? pdc_pkg::ST_RESTART
                                                       : pdc_pkg::ST_LOAD;
        end
      end
      pdc_pkg::ST_LOAD: state_next = pdc_pkg::ST_MUL;
      pdc_pkg::ST_MUL: begin
        if (mcnt == pdc_pkg::MSTEP_DONE) begin
          state_next = (dt_q == '0) ? pdc_pkg::ST_TERM : pdc_pkg::ST_DIV;
        end
      end
      pdc_pkg::ST_DIV: begin
        if (dcnt == pdc_pkg::DIV_LAST) state_next = pdc_pkg::ST_TERM;
      end
      pdc_pkg::ST_TERM: state_next = pdc_pkg::ST_ACC;
      pdc_pkg::ST_ACC: begin
        if (acnt == pdc_pkg::ASTEP_D) state_next = pdc_pkg::ST_FIN;
      end
      pdc_pkg::ST_FIN, pdc_pkg::ST_RESTART: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = pdc_pkg::ST_IDLE;
        end
      end
      default: state_next = pdc_pkg::ST_IDLE;
    endcase
  end

  assign in_take = in_valid && in_ready;

  // ---- control state, configuration and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pdc_pkg::ST_IDLE;
      mcnt          <= '0;
      dcnt          <= '0;
      acnt          <= '0;
      out_valid     <= 1'b0;
      prop_gain     <= pdc_pkg::RST_PROP_GAIN;
      integral_gain <= pdc_pkg::RST_INTEGRAL_GAIN;
      deriv_gain    <= pdc_pkg::RST_DERIV_GAIN;
      drive_max     <= pdc_pkg::RST_DRIVE_MAX;
      drive_min     <= pdc_pkg::RST_DRIVE_MIN;
      base_value    <= pdc_pkg::RST_BASE_VALUE;
      capture_base  <= 1'b0;
      error_sum     <= '0;
      last_error    <= '0;
      last_drive    <= pdc_pkg::RST_BASE_VALUE;
      offset_level  <= pdc_pkg::RST_BASE_VALUE;
    end else begin
      state <= state_next;

      case (state)
        pdc_pkg::ST_LOAD: mcnt <= '0;
        pdc_pkg::ST_MUL: begin
          mcnt <= mcnt + 1'b1;
          dcnt <= '0;
        end
        pdc_pkg::ST_DIV:  dcnt <= dcnt + 1'b1;
        pdc_pkg::ST_TERM: acnt <= '0;
        pdc_pkg::ST_ACC:  acnt <= acnt + 1'b1;
        default: ;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (out_load && state == pdc_pkg::ST_FIN) begin
        last_drive <= t_drive;
        last_error <= err_q;
        if (!iclamp_q) error_sum <= es_next;
      end

      if (out_load && state == pdc_pkg::ST_RESTART) begin
        error_sum  <= '0;
        last_error <= '0;
        if (capture_base) begin
          offset_level <= last_drive;
        end else begin
          offset_level <= base_value;
          last_drive   <= base_value;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          pdc_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_data;
          pdc_pkg::REG_INTEGRAL_GAIN: integral_gain <= cfg_data;
          pdc_pkg::REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
          pdc_pkg::REG_DRIVE_MAX:     drive_max     <= cfg_data[RW-1:0];
          pdc_pkg::REG_DRIVE_MIN:     drive_min     <= cfg_data[RW-1:0];
          pdc_pkg::REG_BASE_VALUE:    base_value    <= cfg_data[RW-1:0];
          pdc_pkg::REG_CAPTURE_BASE:  capture_base  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // ---- datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      err_q <= error;
      dt_q  <= time_step;
    end

    case (state)
      pdc_pkg::ST_LOAD: begin
        s_p   <= err_q[DW-1];
        mag_p <= ep_mag;
        s_i   <= ai[SW];
        mag_i <= ai_mag;
        s_d   <= ad[DW];
        mag_d <= ad_mag;
      end
      pdc_pkg::ST_MUL: begin
        mul_q <= mul_prod;
        case (mcnt)
          pdc_pkg::MSTEP_ILO: prod_p <= mul_q;
          pdc_pkg::MSTEP_IHI: prod_i <= PI_W'(mul_q);
          pdc_pkg::MSTEP_D:   prod_i <= prod_i + (PI_W'(mul_q) << DW);
          pdc_pkg::MSTEP_DONE: begin
            div_n <= mul_q;
            rem   <= '0;
          end
          default: ;
        endcase
      end
      pdc_pkg::ST_DIV: begin
        div_n <= {div_n[AW-3:0], ge1, ge2};
        rem   <= r2s[DW-1:0];
      end
      pdc_pkg::ST_TERM: begin
        term_p   <= p_val;
        term_i   <= AW'(i_fin);
        term_d   <= d_val;
        iclamp_q <= iclamp;
        acc      <= AW'(offset_level) << FRAC_BITS;
      end
      pdc_pkg::ST_ACC: acc <= acc + addend;
      default: ;
    endcase

    if (out_load) begin
      if (state == pdc_pkg::ST_FIN) begin
        drive_value      <= t_drive;
        drive_clamped    <= dclamp;
        integral_clamped <= iclamp_q;
        step_zero        <= (dt_q == '0);
      end else begin
        drive_value      <= capture_base ? last_drive : base_value;
        drive_clamped    <= 1'b0;
        integral_clamped <= 1'b0;
        step_zero        <= 1'b0;
      end
    end
  end

  // ---- checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while a beat is in flight");

  a_clamp_on_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_clamped |-> drive_value == drive_max || drive_value == drive_min)
    else $error("clamped drive not at a bound");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == pdc_pkg::ST_DIV |-> dt_q != '0)
    else $error("divider running on zero time step");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

`default_nettype wire
